>>> hdl/assert_macros.svh
// Assertion helpers shared by the detector's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge, skipped while arst_n is low.
`define FCD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("foot contact check failed");

// Checked on every rising clk edge, also during reset.
`define FCD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("foot contact check failed");

`endif

>>> hdl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Types and constants shared by the foot contact detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcd_pkg;

	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GROUND_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 3'd5;

	// reset values
	localparam logic [9:0]         RST_FRAME_RATE     = 10'd30;
	localparam logic [23:0]        RST_SPEED_LIMIT    = 24'd800;
	localparam logic signed [19:0] RST_HEIGHT_LIMIT   = 20'sd80;
	localparam logic signed [19:0] RST_GROUND_LEVEL   = 20'sd0;
	localparam logic [4:0]         RST_WINDOW_LENGTH  = 5'd5;
	localparam logic [16:0]        RST_SMOOTHING_GAIN = 17'd19661;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	typedef struct packed {
		logic [9:0]         frame_rate;
		logic [23:0]        speed_limit;
		logic signed [19:0] height_limit;
		logic signed [19:0] ground_level;
		logic [4:0]         window_length;
		logic [16:0]        smoothing_gain;
	} fcd_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       calc_a;
		logic       calc_b;
		logic [1:0] coord;
		logic       decide;
		logic       prod;
		logic       emit;
	} fcd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_result;
		logic more;
		logic out_free;
	} fcd_status_t;

endpackage

`default_nettype wire

>>> hdl/fcd_ctrl.sv
// ----------------------------------------------------------------------------
// fcd_ctrl
// Sequencer: capture, pipelined steps over the three coordinates, decide, then one blend
// product and one emit per result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fcd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire fcd_pkg::fcd_status_t st,
	output fcd_pkg::fcd_cmd_t        cmd
);
	import fcd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_DECIDE,
		S_PROD,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] phase_q;

	// state and phase counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
						phase_q <= '0;
					end
				end
				S_CALC: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= st.has_result ? S_PROD : S_IDLE;
				end
				S_PROD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (st.out_free) state_q <= st.more ? S_PROD : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd        = '0;
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.calc_a = (state_q == S_CALC) && (phase_q != 2'd3);
		cmd.calc_b = (state_q == S_CALC) && (phase_q != 2'd0);
		cmd.coord  = phase_q;
		cmd.decide = (state_q == S_DECIDE);
		cmd.prod   = (state_q == S_PROD);
		cmd.emit   = (state_q == S_EMIT) && st.out_free;
	end

	`FCD_ASSERT(a_emit_next, cmd.emit |=> (state_q == S_PROD || state_q == S_IDLE))
	`FCD_ASSERT(a_load_starts_calc, cmd.load |=> (state_q == S_CALC && phase_q == 2'd0))

endmodule

`default_nettype wire

>>> hdl/fcd_dp.sv
// ----------------------------------------------------------------------------
// fcd_dp
// Datapath: speed and height tests, raw flag history, window check,
// blend update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fcd_dp #(
	parameter int MAX_HALF_WINDOW = 15,
	parameter int POSITION_BITS   = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fcd_pkg::fcd_cfg_t               cfg,
	input  wire fcd_pkg::fcd_cmd_t               cmd,
	output fcd_pkg::fcd_status_t                 st,
	input  wire logic signed [POSITION_BITS-1:0] left_x,
	input  wire logic signed [POSITION_BITS-1:0] left_y,
	input  wire logic signed [POSITION_BITS-1:0] left_z,
	input  wire logic signed [POSITION_BITS-1:0] right_x,
	input  wire logic signed [POSITION_BITS-1:0] right_y,
	input  wire logic signed [POSITION_BITS-1:0] right_z,
	input  wire logic                            final_frame,
	input  wire logic                            out_ready,
	output logic                                 out_valid,
	output logic                                 left_contact,
	output logic                                 right_contact,
	output logic [16:0]                          left_weight,
	output logic [16:0]                          right_weight,
	output logic                                 clip_done
);
	import fcd_pkg::*;

	localparam int PB        = POSITION_BITS;
	localparam int DW        = PB + 1;
	localparam int YW        = ((PB > 20) ? PB : 20) + 1;
	localparam int HIST_LEN  = 2 * MAX_HALF_WINDOW + 1;
	localparam int COUNT_CAP = (HIST_LEN > 63) ? HIST_LEN : 63;
	localparam int IW        = $clog2(COUNT_CAP + 1);
	localparam logic [IW-1:0] CAP_V  = IW'(COUNT_CAP);
	localparam logic [IW-1:0] MHW_V  = IW'(MAX_HALF_WINDOW);
	localparam logic [IW-1:0] HLAST  = IW'(HIST_LEN - 1);

	// frame capture
	logic signed [PB-1:0] cur_q  [2][3];
	logic signed [PB-1:0] prev_q [2][3];
	logic                 fin_q;
	logic [47:0]          t2_q;

	// speed computation
	logic [33:0] e_s1    [2];
	logic [1:0]  eovf_s1;
	logic [49:0] acc_q   [2];
	logic [1:0]  sovf_q;

	// clip state
	logic [HIST_LEN-1:0] hist_q [2];
	logic [IW-1:0]       count_q;
	logic [16:0]         blend_q [2];
	logic                started_q;

	// result sequencing
	logic [IW-1:0] a_q;
	logic [IW-1:0] h_q;
	logic          special_q;
	logic signed [35:0] p_s1 [2];
	logic [1:0]    hit_s1;

	// output register
	logic        out_valid_q;
	logic [1:0]  oc_q;
	logic [16:0] ow_q [2];
	logic        odone_q;

	// stage A: |displacement| times frame rate, one coordinate
	logic [DW-1:0] d_abs [2];
	logic [1:0]    d_ovf;
	always_comb begin
		logic signed [DW-1:0] df;
		for (int f = 0; f < 2; f++) begin
			df = DW'(cur_q[f][cmd.coord]) - DW'(prev_q[f][cmd.coord]);
			d_abs[f] = df[DW-1] ? DW'(-df) : DW'(df);
			d_ovf[f] = ((d_abs[f] >> 24) != '0);
		end
	end

	// raw contact and emission plan
	logic [1:0]    raw;
	logic          first;
	logic [IW-1:0] count_new;
	logic [IW-1:0] h_c;
	logic [IW-1:0] top_c;
	always_comb begin
		logic          slow;
		logic signed [YW-1:0] y_e;
		first     = (count_q == '0);
		count_new = (count_q == CAP_V) ? CAP_V : count_q + IW'(1);
		h_c       = IW'(cfg.window_length >> 1);
		if (h_c > MHW_V) h_c = MHW_V;
		top_c     = (h_c < count_new - IW'(1)) ? h_c : count_new - IW'(1);
		for (int f = 0; f < 2; f++) begin
			slow = (t2_q != '0) &&
				(first || (cfg.frame_rate == '0) ||
				 (!sovf_q[f] && (acc_q[f] < 50'(t2_q))));
			y_e = YW'(cur_q[f][1]);
			raw[f] = slow && ((y_e - YW'(cfg.ground_level)) < YW'(cfg.height_limit));
		end
	end

	// window check for the current result
	logic [IW:0]   sum_ah;
	logic [IW-1:0] last_c;
	logic [1:0]    hit_c;
	always_comb begin
		logic [HIST_LEN-1:0] mask;
		sum_ah = (IW+1)'(a_q) + (IW+1)'(h_q);
		last_c = count_q - IW'(1);
		if (sum_ah < (IW+1)'(last_c)) last_c = sum_ah[IW-1:0];
		if (last_c > HLAST) last_c = HLAST;
		for (int i = 0; i < HIST_LEN; i++) mask[i] = (IW'(i) <= last_c);
		for (int f = 0; f < 2; f++) hit_c[f] = &(hist_q[f] | ~mask);
	end

	// blend update from the registered product
	logic [16:0] blend_new [2];
	always_comb begin
		logic signed [20:0] sum;
		for (int f = 0; f < 2; f++) begin
			sum = 21'($signed({4'd0, blend_q[f]})) + 21'(p_s1[f] >>> 16);
			if (!started_q)              blend_new[f] = hit_s1[f] ? ONE_Q16 : '0;
			else if (sum < 0)            blend_new[f] = '0;
			else if (sum > 21'sd65536)   blend_new[f] = ONE_Q16;
			else                         blend_new[f] = sum[16:0];
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q[0][0] <= left_x;
			cur_q[0][1] <= left_y;
			cur_q[0][2] <= left_z;
			cur_q[1][0] <= right_x;
			cur_q[1][1] <= right_y;
			cur_q[1][2] <= right_z;
			fin_q       <= final_frame;
			t2_q        <= cfg.speed_limit * cfg.speed_limit;
			acc_q[0]    <= '0;
			acc_q[1]    <= '0;
			sovf_q      <= '0;
		end
		if (cmd.calc_a) begin
			for (int f = 0; f < 2; f++) begin
				e_s1[f]    <= 24'(d_abs[f]) * cfg.frame_rate;
				eovf_s1[f] <= d_ovf[f];
			end
		end
		if (cmd.calc_b) begin
			for (int f = 0; f < 2; f++) begin
				acc_q[f]  <= acc_q[f] + 50'(e_s1[f][23:0] * e_s1[f][23:0]);
				sovf_q[f] <= sovf_q[f] | eovf_s1[f] | (e_s1[f][33:24] != '0);
			end
		end
		if (cmd.decide) begin
			h_q       <= h_c;
			special_q <= fin_q && (count_new == IW'(1));
			a_q       <= fin_q ? ((count_new == IW'(1)) ? '0 : top_c) : h_c;
		end
		if (cmd.prod) begin
			for (int f = 0; f < 2; f++) begin
				p_s1[f] <= $signed({1'b0, cfg.smoothing_gain}) *
					($signed({1'b0, (hit_c[f] ? ONE_Q16 : 17'd0)}) -
					 $signed({1'b0, blend_q[f]}));
			end
			hit_s1 <= special_q ? 2'b00 : hit_c;
		end
		if (cmd.emit) begin
			a_q     <= a_q - IW'(1);
			oc_q    <= hit_s1;
			ow_q[0] <= special_q ? '0 : blend_new[0];
			ow_q[1] <= special_q ? '0 : blend_new[1];
			odone_q <= fin_q && (a_q == '0);
		end
	end

	// clip state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int f = 0; f < 2; f++) begin
				for (int c = 0; c < 3; c++) prev_q[f][c] <= '0;
				hist_q[f]  <= '0;
				blend_q[f] <= '0;
			end
			count_q     <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decide) begin
				for (int f = 0; f < 2; f++) begin
					for (int c = 0; c < 3; c++) prev_q[f][c] <= cur_q[f][c];
					hist_q[f] <= (hist_q[f] << 1) | HIST_LEN'(raw[f]);
				end
				count_q <= count_new;
			end
			if (cmd.emit) begin
				if (fin_q && (special_q || a_q == '0)) begin
					// clip ends: back to the empty state
					for (int f = 0; f < 2; f++) begin
						for (int c = 0; c < 3; c++) prev_q[f][c] <= '0;
						hist_q[f]  <= '0;
						blend_q[f] <= '0;
					end
					count_q   <= '0;
					started_q <= 1'b0;
				end else begin
					blend_q[0] <= blend_new[0];
					blend_q[1] <= blend_new[1];
					started_q  <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status
	always_comb begin
		st.has_result = fin_q || (count_new > h_c);
		st.more       = fin_q && !special_q && (a_q != '0);
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign left_contact  = oc_q[0];
	assign right_contact = oc_q[1];
	assign left_weight   = ow_q[0];
	assign right_weight  = ow_q[1];
	assign clip_done     = odone_q;

	`FCD_ASSERT(a_blend_range, (blend_q[0] <= ONE_Q16) && (blend_q[1] <= ONE_Q16))
	`FCD_ASSERT(a_emit_slot, cmd.emit |-> (!out_valid_q || out_ready))
	`FCD_ASSERT(a_count_cap, count_q <= CAP_V)

endmodule

`default_nettype wire

>>> hdl/foot_contact_detector_unit.sv
// Each frame runs capture, the pipelined coordinate steps and decide, then each
// result takes a blend product and an output load that waits for a free output slot.
// A new frame is taken only in idle, once the last frame's results are loaded; a
// final frame gives up to h+1 results, with h the capped half window length.
// Reset (arst_n low, asynchronous) clears the clip state, the output valid
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// foot_contact_detector_unit
// Per-frame foot contact detection with windowed confirmation and blends.
// ----------------------------------------------------------------------------
`default_nettype none

module foot_contact_detector_unit #(
	parameter int MAX_HALF_WINDOW = 15,
	parameter int POSITION_BITS   = 20
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fcd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [fcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [POSITION_BITS-1:0]     left_x,
	input  wire logic signed [POSITION_BITS-1:0]     left_y,
	input  wire logic signed [POSITION_BITS-1:0]     left_z,
	input  wire logic signed [POSITION_BITS-1:0]     right_x,
	input  wire logic signed [POSITION_BITS-1:0]     right_y,
	input  wire logic signed [POSITION_BITS-1:0]     right_z,
	input  wire logic                                final_frame,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     left_contact,
	output logic                                     right_contact,
	output logic [16:0]                              left_weight,
	output logic [16:0]                              right_weight,
	output logic                                     clip_done
);
	import fcd_pkg::*;

	fcd_cfg_t    cfg_q;
	fcd_cmd_t    cmd;
	fcd_status_t st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_rate     <= RST_FRAME_RATE;
			cfg_q.speed_limit    <= RST_SPEED_LIMIT;
			cfg_q.height_limit   <= RST_HEIGHT_LIMIT;
			cfg_q.ground_level   <= RST_GROUND_LEVEL;
			cfg_q.window_length  <= RST_WINDOW_LENGTH;
			cfg_q.smoothing_gain <= RST_SMOOTHING_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_RATE:     cfg_q.frame_rate     <= cfg_data[9:0];
				REG_SPEED_LIMIT:    cfg_q.speed_limit    <= cfg_data[23:0];
				REG_HEIGHT_LIMIT:   cfg_q.height_limit   <= $signed(cfg_data[19:0]);
				REG_GROUND_LEVEL:   cfg_q.ground_level   <= $signed(cfg_data[19:0]);
				REG_WINDOW_LENGTH:  cfg_q.window_length  <= cfg_data[4:0];
				REG_SMOOTHING_GAIN: cfg_q.smoothing_gain <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	fcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	fcd_dp #(
		.MAX_HALF_WINDOW (MAX_HALF_WINDOW),
		.POSITION_BITS   (POSITION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.st            (st),
		.left_x        (left_x),
		.left_y        (left_y),
		.left_z        (left_z),
		.right_x       (right_x),
		.right_y       (right_y),
		.right_z       (right_z),
		.final_frame   (final_frame),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.left_contact  (left_contact),
		.right_contact (right_contact),
		.left_weight   (left_weight),
		.right_weight  (right_weight),
		.clip_done     (clip_done)
	);

endmodule

`default_nettype wire

>>> verif/tb_foot_contact_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_foot_contact_detector_unit
// Self-checking bench: motion clips go in over a valid/ready channel, a
// behavioral copy of the detector predicts each result, and a monitor
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_foot_contact_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import fcd_pkg::*;

	localparam int HALF_MAX   = 15;
	localparam int HIST_DEPTH = 2 * HALF_MAX + 1;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		logic signed [19:0] lx, ly, lz, rx, ry, rz;
		bit                 fin;
	} frame_t;

	typedef struct {
		bit          lc, rc, done;
		logic [16:0] lw, rw;
	} contact_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [19:0] left_x = '0, left_y = '0, left_z = '0;
	logic signed [19:0] right_x = '0, right_y = '0, right_z = '0;
	logic final_frame = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic left_contact, right_contact, clip_done;
	logic [16:0] left_weight, right_weight;

	foot_contact_detector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.left_x(left_x), .left_y(left_y), .left_z(left_z),
		.right_x(right_x), .right_y(right_y), .right_z(right_z),
		.final_frame(final_frame),
		.out_valid(out_valid), .out_ready(out_ready),
		.left_contact(left_contact), .right_contact(right_contact),
		.left_weight(left_weight), .right_weight(right_weight),
		.clip_done(clip_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor copy of configuration and clip state
	longint unsigned m_rate, m_speed;
	longint          m_height, m_ground;
	int              m_window;
	longint          m_gain;
	longint          prev_l[3], prev_r[3];
	bit [HIST_DEPTH-1:0] hist_l, hist_r;
	int              clip_frames;
	longint          blend_l, blend_r;
	bit              blend_live;

	contact_result_t expected_contacts[$];
	int  errors = 0;
	bit  hold_req = 1'b0;
	longint walk_l[3], walk_r[3];

	function automatic void clear_clip_model();
		for (int i = 0; i < 3; i++) begin
			prev_l[i] = 0;
			prev_r[i] = 0;
		end
		hist_l = '0;
		hist_r = '0;
		clip_frames = 0;
		blend_l = 0;
		blend_r = 0;
		blend_live = 1'b0;
	endfunction

	// raw contact: slow enough and low enough
	function automatic bit foot_raw(longint p0, longint p1, longint p2,
			longint q0, longint q1, longint q2, bit first);
		longint unsigned t2, f2, bound, d2, d;
		longint p[3], q[3];
		bit slow;
		p = '{p0, p1, p2};
		q = '{q0, q1, q2};
		t2 = m_speed * m_speed;
		if (t2 == 0) begin
			slow = 1'b0;
		end else if (first || m_rate == 0) begin
			slow = 1'b1;
		end else begin
			f2 = m_rate * m_rate;
			bound = (t2 - 1) / f2;
			d2 = 0;
			for (int i = 0; i < 3; i++) begin
				d = (p[i] >= q[i]) ? p[i] - q[i] : q[i] - p[i];
				d2 += d * d;
			end
			slow = (d2 <= bound);
		end
		return slow && (p1 - m_ground < m_height);
	endfunction

	function automatic bit window_set(bit [HIST_DEPTH-1:0] h, int last);
		for (int i = 0; i <= last && i < HIST_DEPTH; i++)
			if (!h[i]) return 1'b0;
		return 1'b1;
	endfunction

	// floor step toward target, clamped to 0..one
	function automatic longint blend_step(longint b, longint target);
		longint p;
		p = m_gain * (target - b);
		b = b + (p >>> 16);
		if (b < 0) b = 0;
		if (b > 65536) b = 65536;
		return b;
	endfunction

	function automatic void predict_frame(frame_t f);
		longint lp[3], rp[3];
		bit first, lraw, rraw, lc, rc;
		int h, top, last;
		contact_result_t r;
		lp = '{f.lx, f.ly, f.lz};
		rp = '{f.rx, f.ry, f.rz};
		first = (clip_frames == 0);
		lraw = foot_raw(lp[0], lp[1], lp[2], prev_l[0], prev_l[1], prev_l[2], first);
		rraw = foot_raw(rp[0], rp[1], rp[2], prev_r[0], prev_r[1], prev_r[2], first);
		hist_l = {hist_l[HIST_DEPTH-2:0], lraw};
		hist_r = {hist_r[HIST_DEPTH-2:0], rraw};
		prev_l = lp;
		prev_r = rp;
		if (clip_frames < 63) clip_frames++;
		if (f.fin && clip_frames == 1) begin
			r = '{lc: 0, rc: 0, done: 1, lw: 0, rw: 0};
			expected_contacts.push_back(r);
			clear_clip_model();
			return;
		end
		h = m_window >> 1;
		if (h > HALF_MAX) h = HALF_MAX;
		if (f.fin) top = (h < clip_frames - 1) ? h : clip_frames - 1;
		else if (clip_frames > h) top = h;
		else return;
		for (int a = top; a >= 0; a--) begin
			last = (a + h < clip_frames - 1) ? a + h : clip_frames - 1;
			lc = window_set(hist_l, last);
			rc = window_set(hist_r, last);
			if (!blend_live) begin
				blend_l = lc ? 65536 : 0;
				blend_r = rc ? 65536 : 0;
				blend_live = 1'b1;
			end else begin
				blend_l = blend_step(blend_l, lc ? 65536 : 0);
				blend_r = blend_step(blend_r, rc ? 65536 : 0);
			end
			r.lc = lc;
			r.rc = rc;
			r.lw = blend_l[16:0];
			r.rw = blend_r[16:0];
			r.done = f.fin && (a == 0);
			expected_contacts.push_back(r);
			if (!f.fin) break;
		end
		if (f.fin) clear_clip_model();
	endfunction

	// register write, mirrored into the predictor
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
		cfg_index = idx;
		cfg_data = value[CFG_DATA_W-1:0];
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_FRAME_RATE:     m_rate = value[9:0];
			REG_SPEED_LIMIT:    m_speed = value[23:0];
			REG_HEIGHT_LIMIT:   m_height = longint'($signed(value[19:0]));
			REG_GROUND_LEVEL:   m_ground = longint'($signed(value[19:0]));
			REG_WINDOW_LENGTH:  m_window = value[4:0];
			REG_SMOOTHING_GAIN: m_gain = value[16:0];
			default: ;
		endcase
	endtask

	task automatic set_all(longint fr, longint sl, longint hl, longint gl,
			longint wl, longint sg);
		write_reg(REG_FRAME_RATE, fr);
		write_reg(REG_SPEED_LIMIT, sl);
		write_reg(REG_HEIGHT_LIMIT, hl);
		write_reg(REG_GROUND_LEVEL, gl);
		write_reg(REG_WINDOW_LENGTH, wl);
		write_reg(REG_SMOOTHING_GAIN, sg);
	endtask

	// wait until every predicted result is out, then let the pipe settle
	task automatic drain();
		while (expected_contacts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one request on the frame channel
	task automatic send_frame(frame_t f);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		left_x = f.lx; left_y = f.ly; left_z = f.lz;
		right_x = f.rx; right_y = f.ry; right_z = f.rz;
		final_frame = f.fin;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_frame(f);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic frame_t noise_frame(bit fin);
		frame_t f;
		f.lx = 20'($urandom); f.ly = 20'($urandom); f.lz = 20'($urandom);
		f.rx = 20'($urandom); f.ry = 20'($urandom); f.rz = 20'($urandom);
		f.fin = fin;
		return f;
	endfunction

	// slow walk near the ground with occasional jumps and lifts
	function automatic frame_t walk_frame(bit fin, int step);
		frame_t f;
		for (int i = 0; i < 3; i++) begin
			walk_l[i] += $signed($urandom_range(0, 2 * step)) - step;
			walk_r[i] += $signed($urandom_range(0, 2 * step)) - step;
			if ($urandom_range(0, 15) == 0) walk_l[i] += 400;
			if ($urandom_range(0, 15) == 0) walk_r[i] -= 400;
		end
		walk_l[1] = m_ground + $urandom_range(0, 160) - 40;
		walk_r[1] = m_ground + $urandom_range(0, 160) - 40;
		f.lx = 20'(walk_l[0]); f.ly = 20'(walk_l[1]); f.lz = 20'(walk_l[2]);
		f.rx = 20'(walk_r[0]); f.ry = 20'(walk_r[1]); f.rz = 20'(walk_r[2]);
		f.fin = fin;
		return f;
	endfunction

	task automatic send_clip(int len, int step, bit closed);
		for (int i = 0; i < 3; i++) begin
			walk_l[i] = $signed($urandom_range(0, 2000)) - 1000;
			walk_r[i] = $signed($urandom_range(0, 2000)) - 1000;
		end
		for (int i = 0; i < len; i++)
			send_frame(walk_frame(closed && i == len - 1, step));
	endtask

	// directed: defaults, one-frame clip, position extremes, big jumps
	task automatic test_directed_defaults();
		frame_t f;
		send_clip(8, 3, 1'b1);
		send_frame(noise_frame(1'b1));
		f = '{lx: 20'sh7FFFF, ly: 20'sh80000, lz: 20'sh7FFFF,
			rx: 20'sh80000, ry: 20'sh7FFFF, rz: 20'sh80000, fin: 1'b0};
		send_frame(f);
		f = '{lx: 20'sh80000, ly: 20'sh80000, lz: 20'sh80000,
			rx: 20'sh7FFFF, ry: 20'sh80000, rz: 20'sh7FFFF, fin: 1'b0};
		send_frame(f);
		send_frame(f);
		f.fin = 1'b1;
		send_frame(f);
		drain();
	endtask

	// directed: register extremes, each with a short clip
	task automatic test_register_extremes();
		set_all(1, 24'hFFFFFF, 20'h7FFFF, 20'h80000, 31, 65536);
		send_clip(6, 4, 1'b1);
		drain();
		set_all(1000, 0, 20'h80000, 20'h7FFFF, 0, 0);
		send_clip(4, 4, 1'b1);
		drain();
		set_all(0, 1, 200, -30, 1, 1);
		send_clip(4, 4, 1'b1);
		drain();
		set_all(30, 800, 80, 0, 5, 19661);
	endtask

	// random clips under several settings
	task automatic test_random_clips();
		int sent, len, kind;
		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_all(30, 800, 80, 0, 5, 19661);
				1: set_all(60, 2000, 120, 50, 9, 40000);
				2: set_all($urandom_range(1, 1000), $urandom_range(0, 24'hFFFFFF),
					$urandom, $urandom, $urandom_range(0, 31), $urandom_range(0, 65536));
				3: set_all(1000, 24'hFFFFFF, 160, -20, 31, 65536);
				default: set_all(25, 500, 100, 0, 3, 8000);
			endcase
			while (sent < 31 * (phase + 1)) begin
				len = $urandom_range(1, 14);
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					send_clip(len, $urandom_range(1, 12), 1'b1);
				end else if (kind == 7) begin
					send_clip(len, 6, 1'b0);
				end else begin
					for (int i = 0; i < len; i++)
						send_frame(noise_frame(i == len - 1 && kind == 8));
				end
				sent += len;
			end
			drain();
		end
	endtask

	// long receiver hold-off, then a sender pause until all results are out
	task automatic test_backpressure();
		set_all(30, 800, 80, 0, 9, 19661);
		hold_req = 1'b1;
		send_clip(14, 3, 1'b1);
		send_clip(5, 3, 1'b1);
		while (expected_contacts.size() != 0) @(negedge clk);
		send_clip(6, 3, 1'b1);
		drain();
	endtask

	// result monitor
	always @(posedge clk) begin
		contact_result_t e;
		if (out_valid && out_ready) begin
			if (expected_contacts.size() == 0) begin
				$display("%t unexpected result: exp none got lc=%0d rc=%0d",
					$realtime, left_contact, right_contact);
				errors++;
			end else begin
				e = expected_contacts.pop_front();
				if (left_contact !== e.lc) begin
					$display("%t left_contact exp %0d got %0d", $realtime, e.lc, left_contact);
					errors++;
				end
				if (right_contact !== e.rc) begin
					$display("%t right_contact exp %0d got %0d", $realtime, e.rc, right_contact);
					errors++;
				end
				if (left_weight !== e.lw) begin
					$display("%t left_weight exp %0d got %0d", $realtime, e.lw, left_weight);
					errors++;
				end
				if (right_weight !== e.rw) begin
					$display("%t right_weight exp %0d got %0d", $realtime, e.rw, right_weight);
					errors++;
				end
				if (clip_done !== e.done) begin
					$display("%t clip_done exp %0d got %0d", $realtime, e.done, clip_done);
					errors++;
				end
			end
		end
	end

	// receiver: random wait per result, long hold-off on request
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			wait_n = $urandom_range(0, 4);
			if ($urandom_range(0, 3) == 0) wait_n = 0;
			out_ready = 1'b0;
			repeat (wait_n) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// watchdog on cycles with no traffic
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
			else quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		m_rate = RST_FRAME_RATE;
		m_speed = RST_SPEED_LIMIT;
		m_height = RST_HEIGHT_LIMIT;
		m_ground = RST_GROUND_LEVEL;
		m_window = RST_WINDOW_LENGTH;
		m_gain = RST_SMOOTHING_GAIN;
		clear_clip_model();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed_defaults();
		test_register_extremes();
		test_backpressure();
		test_random_clips();
		drain();
		if (errors == 0 && expected_contacts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
